@@ rtl/pulse_width_frame_transmitter_top_assert.svh @@
// Assertion macros shared by the checker.
`ifndef PULSE_WIDTH_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define PULSE_WIDTH_FRAME_TRANSMITTER_TOP_ASSERT_SVH

// Clocked check, quiet while reset is held.
`define PWFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Clocked check that also runs through reset.
`define PWFT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset check failed");

`endif

@@ rtl/pwft_pkg.sv @@
package pwft_pkg;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_STATION_ID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_UNITS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_UNITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_UNITS    = 3'd4;

  localparam logic [2:0] STATION_ID_RST   = 3'd5;
  localparam logic [3:0] REPEAT_COUNT_RST = 4'd10;
  localparam logic [3:0] LONG_UNITS_RST   = 4'd3;
  localparam logic [3:0] SHORT_UNITS_RST  = 4'd1;
  localparam logic [5:0] GAP_UNITS_RST    = 6'd31;

  localparam logic [3:0] BIT_INDEX_MSB = 4'd15;

  typedef enum logic [3:0] {
    PH_BIT_HIGH = 4'b0001,
    PH_BIT_LOW  = 4'b0010,
    PH_SYNC     = 4'b0100,
    PH_GAP      = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0] station_id;
    logic [3:0] repeat_count;
    logic [3:0] long_units;
    logic [3:0] short_units;
    logic [5:0] gap_units;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [5:0] int_part;
    logic [3:0] sequence_req;
    logic       negative;
  } in_item_t;

  typedef struct packed {
    logic line;
    logic busy_res;
    logic done_res;
    logic rejected;
  } result_t;

  function automatic logic [5:0] at_least_one(input logic [5:0] v);
    return (v == 6'd0) ? 6'd1 : v;
  endfunction

  // Bit 14 makes bits 0 to 14 even parity; bit 15 stays clear.
  function automatic logic [15:0] pack_word(input logic [5:0] ip, input logic [3:0] seq,
                                            input logic neg, input logic [2:0] sid);
    logic [13:0] w;
    w = {sid, neg, seq, ip};
    return {1'b0, ^w, w};
  endfunction

endpackage

@@ rtl/pwft_core.sv @@
module pwft_core
  import pwft_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  in_item_t item,
  input  cfg_t     cfg,
  output result_t  res
);

  logic [15:0] frame_word_r, frame_word_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  phase_t      phase_r, phase_nxt;
  logic [5:0]  unit_count_r, unit_count_nxt;
  logic [3:0]  repeats_left_r, repeats_left_nxt;
  logic        active_r, active_nxt;

  logic [5:0]  lng, sht, gap, dur, unit_inc, reps_init;
  logic        bit_val;

  always_comb begin
    lng       = at_least_one({2'b00, cfg.long_units});
    sht       = at_least_one({2'b00, cfg.short_units});
    gap       = at_least_one(cfg.gap_units);
    reps_init = at_least_one({2'b00, cfg.repeat_count});
    bit_val   = frame_word_r[bit_index_r];
    unit_inc  = unit_count_r + 6'd1;

    frame_word_nxt   = frame_word_r;
    bit_index_nxt    = bit_index_r;
    phase_nxt        = phase_r;
    unit_count_nxt   = unit_count_r;
    repeats_left_nxt = repeats_left_r;
    active_nxt       = active_r;
    res              = '0;
    dur              = sht;

    if (item.cmd) begin
      res.busy_res = 1'b1;
      if (active_r) begin
        res.rejected = 1'b1;
      end else begin
        frame_word_nxt   = pack_word(item.int_part, item.sequence_req, item.negative,
                                     cfg.station_id);
        bit_index_nxt    = BIT_INDEX_MSB;
        phase_nxt        = PH_BIT_HIGH;
        unit_count_nxt   = '0;
        repeats_left_nxt = reps_init[3:0];
        active_nxt       = 1'b1;
      end
    end else if (active_r) begin
      res.busy_res = 1'b1;
      unique case (phase_r)
        PH_BIT_HIGH: begin
          res.line = 1'b1;
          dur      = bit_val ? lng : sht;
        end
        PH_BIT_LOW: begin
          res.line = 1'b0;
          dur      = bit_val ? sht : lng;
        end
        PH_SYNC: begin
          res.line = 1'b1;
          dur      = sht;
        end
        PH_GAP: begin
          res.line = 1'b0;
          dur      = gap;
        end
        default: begin
          res.line = 1'b0;
          dur      = gap;
        end
      endcase

      // A duration shortened mid-phase ends the phase on this unit.
      if (unit_inc >= dur) begin
        unit_count_nxt = '0;
        unique case (phase_r)
          PH_BIT_HIGH: phase_nxt = PH_BIT_LOW;
          PH_BIT_LOW: begin
            if (bit_index_r == 4'd0) begin
              phase_nxt = PH_SYNC;
            end else begin
              bit_index_nxt = bit_index_r - 4'd1;
              phase_nxt     = PH_BIT_HIGH;
            end
          end
          PH_SYNC: phase_nxt = PH_GAP;
          default: begin
            repeats_left_nxt = repeats_left_r - 4'd1;
            bit_index_nxt    = BIT_INDEX_MSB;
            phase_nxt        = PH_BIT_HIGH;
            if (repeats_left_r == 4'd1) begin
              active_nxt   = 1'b0;
              res.done_res = 1'b1;
            end
          end
        endcase
      end else begin
        unit_count_nxt = unit_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_word_r   <= '0;
      bit_index_r    <= BIT_INDEX_MSB;
      phase_r        <= PH_BIT_HIGH;
      unit_count_r   <= '0;
      repeats_left_r <= '0;
      active_r       <= 1'b0;
    end else if (step_en) begin
      frame_word_r   <= frame_word_nxt;
      bit_index_r    <= bit_index_nxt;
      phase_r        <= phase_nxt;
      unit_count_r   <= unit_count_nxt;
      repeats_left_r <= repeats_left_nxt;
      active_r       <= active_nxt;
    end
  end

endmodule

@@ rtl/pulse_width_frame_transmitter_top.sv @@
// Pulse-width frame transmitter. A start beat (in_tuser = 1) packs a 16-bit word from
// the beat and the station id register; every tick beat (in_tuser = 0) is one pulse unit
// and yields one result beat with the line level, sent MSB first, long/short high and
// low phases per bit, then a sync high and a gap, for the latched number of repetitions.
// One input beat is taken per clock while the skid stage is empty; its result is
// registered in the output register or, while the output is stalled, in a one-entry
// skid stage that keeps input acceptance going for one beat. Configuration writes are
// always accepted and should only be made while no frame is being sent.
module pulse_width_frame_transmitter_top
  import pwft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // int_part[5:0], sequence_req[9:6], negative[10]
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // line[0], busy_res[1], rejected[2]
  output logic                  out_tlast,  // done_res
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  in_item_t item;
  result_t  res;
  result_t  out_res_r, out_res_nxt;
  result_t  skid_res_r, skid_res_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  logic     in_fire, out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_id   <= STATION_ID_RST;
      cfg_r.repeat_count <= REPEAT_COUNT_RST;
      cfg_r.long_units   <= LONG_UNITS_RST;
      cfg_r.short_units  <= SHORT_UNITS_RST;
      cfg_r.gap_units    <= GAP_UNITS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STATION_ID:   cfg_r.station_id   <= cfg_data[2:0];
        REG_REPEAT_COUNT: cfg_r.repeat_count <= cfg_data[3:0];
        REG_LONG_UNITS:   cfg_r.long_units   <= cfg_data[3:0];
        REG_SHORT_UNITS:  cfg_r.short_units  <= cfg_data[3:0];
        REG_GAP_UNITS:    cfg_r.gap_units    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.cmd          = in_tuser;
  assign item.int_part     = in_tdata[5:0];
  assign item.sequence_req = in_tdata[9:6];
  assign item.negative     = in_tdata[10];

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  pwft_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .item    (item),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      // drain the skid beat first
      if (out_take) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_res_r.rejected, out_res_r.busy_res, out_res_r.line};
  assign out_tlast  = out_res_r.done_res;

endmodule

@@ rtl/pwft_checker.sv @@
`include "pulse_width_frame_transmitter_top_assert.svh"

module pwft_checker
  import pwft_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  `PWFT_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_tvalid)
  `PWFT_ASSERT(a_done_while_busy, out_tvalid && out_tlast |-> out_tdata[1])
  `PWFT_ASSERT(a_reject_quiet, out_tvalid && out_tdata[2] |-> !out_tlast && !out_tdata[0])
  `PWFT_ASSERT(a_line_needs_busy, out_tvalid && out_tdata[0] |-> out_tdata[1])
  `PWFT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind pulse_width_frame_transmitter_top pwft_checker u_pwft_checker (.*);
